[rtl/core/fcfs_pkg.sv]
// Shared constants and types for the feedback comb filter with running statistics.
// Used by the controller, the datapath and the top level; no dependencies.
package fcfs_pkg;

  // Sample and register widths
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int DELAY_W   = 5;
  localparam int OP_W      = 2;
  localparam int SUM_W     = 48;
  localparam int COUNT_W   = 32;
  localparam int PROD_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  // Delay line depth (power of two, pointer wraps naturally)
  localparam int MAX_DELAY = 16;
  localparam int PTR_W     = $clog2(MAX_DELAY);

  // Divider: one quotient bit per cycle over the whole sum magnitude
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Operation codes
  localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
  localparam logic [OP_W-1:0] OP_AVG    = 2'd1;
  localparam logic [OP_W-1:0] OP_MAX    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 1'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture request, preload divider
    logic mul;       // read delay tap and register the product
    logic div_step;  // one restoring-division step
    logic finish;    // produce result and update statistics
  } fcfs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic count_zero;
  } fcfs_sts_t;

endpackage

[rtl/core/fcfs_ctrl.sv]
// Controller for the comb filter block: request sequencing, divider step count,
// output valid. Depends on fcfs_pkg.
module fcfs_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [fcfs_pkg::OP_W-1:0] operation,
  output logic                     out_valid,
  input  logic                     out_ready,
  output fcfs_pkg::fcfs_cmd_t      cmd,
  input  fcfs_pkg::fcfs_sts_t      sts
);
  import fcfs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 accept;
  logic                 div_last;
  logic                 fin_ok;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  // result register is free or being emptied this cycle
  assign fin_ok   = (state == S_DONE) && (!out_valid || out_ready);

  assign cmd.load     = accept;
  assign cmd.mul      = (state == S_MUL);
  assign cmd.div_step = (state == S_DIV);
  assign cmd.finish   = fin_ok;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_FILTER: state_next = S_MUL;
            OP_AVG:    state_next = sts.count_zero ? S_DONE : S_DIV;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_MUL:  state_next = S_DONE;
      S_DIV:  if (div_last) state_next = S_DONE;
      S_DONE: if (fin_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // divider step counter
      if (state == S_DIV) begin
        div_cnt <= div_last ? '0 : div_cnt + 1'b1;
      end
      // output register valid
      if (fin_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/fcfs_dp.sv]
// Datapath for the comb filter block: config registers, delay line, multiplier,
// statistics, serial divider and result register. Depends on fcfs_pkg.
module fcfs_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fcfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fcfs_pkg::CFG_W-1:0]         cfg_data,
  input  logic [fcfs_pkg::OP_W-1:0]          operation,
  input  logic signed [fcfs_pkg::SAMPLE_W-1:0] sample,
  input  fcfs_pkg::fcfs_cmd_t                cmd,
  output fcfs_pkg::fcfs_sts_t                sts,
  output logic signed [fcfs_pkg::SAMPLE_W-1:0] value,
  output logic                               empty_res
);
  import fcfs_pkg::*;

  // configuration
  logic signed [GAIN_W-1:0] gain;
  logic [DELAY_W-1:0]       delay_len;

  // request capture
  logic [OP_W-1:0]            op_q;
  logic signed [SAMPLE_W-1:0] x_q;

  // delay line with per-entry valid bits (empty entries read as zero)
  logic signed [SAMPLE_W-1:0] line [MAX_DELAY];
  logic [MAX_DELAY-1:0]       line_vld;
  logic [PTR_W-1:0]           wp;

  // statistics
  logic signed [SUM_W-1:0]    run_sum;
  logic [COUNT_W-1:0]         run_cnt;
  logic signed [SAMPLE_W-1:0] run_max;

  // multiplier and divider
  logic signed [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]           dvd;
  logic [COUNT_W-1:0]         rem;
  logic                       neg;

  logic [DELAY_W-1:0]         d_eff;
  logic [PTR_W-1:0]           rd_idx;
  logic signed [PROD_W-1:0]   q_round;
  logic signed [SAMPLE_W+1:0] y_wide;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic [COUNT_W:0]           rem_sh;
  logic                       q_bit;
  logic [SAMPLE_W-1:0]        quot;
  logic [SUM_W-1:0]           sum_mag;

  assign sts.count_zero = (run_cnt == '0);

  // effective delay clamped to 1..MAX_DELAY, tap index behind write pointer
  always_comb begin
    d_eff = delay_len;
    if (delay_len == '0) begin
      d_eff = DELAY_W'(1);
    end else if (delay_len > DELAY_W'(MAX_DELAY)) begin
      d_eff = DELAY_W'(MAX_DELAY);
    end
    rd_idx = wp - d_eff[PTR_W-1:0];
  end

  // round Q2.30 product half up to Q.15, add input, saturate
  always_comb begin
    q_round = (prod + PROD_W'(32'sd16384)) >>> 15;
    y_wide  = (SAMPLE_W+2)'(q_round) + (SAMPLE_W+2)'(x_q);
    if (y_wide > (SAMPLE_W+2)'(32767)) begin
      y_sat = 16'sh7FFF;
    end else if (y_wide < -(SAMPLE_W+2)'(32768)) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y_wide[SAMPLE_W-1:0];
    end
  end

  // divider step: shift in next dividend bit, subtract when it fits
  always_comb begin
    rem_sh = {rem, dvd[SUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, run_cnt});
    quot   = dvd[SAMPLE_W-1:0];
    sum_mag = run_sum[SUM_W-1] ? SUM_W'(-run_sum) : SUM_W'(run_sum);
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= '0;
      delay_len <= DELAY_W'(2);
      line_vld  <= '0;
      wp        <= '0;
      run_sum   <= '0;
      run_cnt   <= '0;
      run_max   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GAIN:  gain      <= cfg_data[GAIN_W-1:0];
          CFG_DELAY: delay_len <= cfg_data[DELAY_W-1:0];
          default: ;
        endcase
      end
      if (cmd.finish) begin
        case (op_q)
          OP_FILTER: begin
            line_vld[wp] <= 1'b1;
            wp           <= wp + 1'b1;
            if (run_cnt != '1) begin
              run_sum <= run_sum + SUM_W'(y_sat);
              run_cnt <= run_cnt + 1'b1;
            end
            if (y_sat > run_max) run_max <= y_sat;
          end
          OP_AVG: begin
            run_sum <= '0;
            run_cnt <= '0;
          end
          OP_MAX: run_max <= '0;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= operation;
      x_q  <= sample;
      dvd  <= sum_mag;
      rem  <= '0;
      neg  <= run_sum[SUM_W-1];
    end
    // delay tap read and product
    if (cmd.mul) begin
      prod <= PROD_W'(gain) *
              (line_vld[rd_idx] ? PROD_W'(line[rd_idx]) : PROD_W'(0));
    end
    if (cmd.div_step) begin
      rem <= q_bit ? COUNT_W'(rem_sh - {1'b0, run_cnt}) : rem_sh[COUNT_W-1:0];
      dvd <= {dvd[SUM_W-2:0], q_bit};
    end
    if (cmd.finish) begin
      empty_res <= (op_q == OP_AVG) && (run_cnt == '0);
      case (op_q)
        OP_FILTER: begin
          line[wp] <= y_sat;
          value    <= y_sat;
        end
        OP_AVG: begin
          if (run_cnt == '0) begin
            value <= '0;
          end else begin
            value <= neg ? SAMPLE_W'(-quot) : quot;
          end
        end
        OP_MAX:  value <= run_max;
        default: value <= '0;
      endcase
    end
  end

endmodule

[rtl/core/feedback_comb_filter_stats.sv]
// Top level of the feedback comb filter with running statistics.
// Depends on fcfs_pkg, fcfs_ctrl and fcfs_dp.
//
//   channel   signals                          direction  handshake
//   in        operation, sample                in         in_valid / in_ready
//   out       value, empty_res                 out        out_valid / out_ready
//   cfg       cfg_index, cfg_data              in         cfg_we (no wait)
//
// One request at a time. Filter request: accept, multiply, finish. Average
// request: accept, the 48-step bit-serial divider, then finish when samples are
// counted; accept and finish when the count is zero. Max request and unused
// codes: accept and finish. Reset is synchronous; the delay line reads as zero
// until written. A new request is taken while a result waits; it stalls only in
// its finish step until the result register is free.
module feedback_comb_filter_stats (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fcfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fcfs_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [fcfs_pkg::OP_W-1:0]            operation,
  input  logic signed [fcfs_pkg::SAMPLE_W-1:0] sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fcfs_pkg::SAMPLE_W-1:0] value,
  output logic                                 empty_res
);
  import fcfs_pkg::*;

  fcfs_cmd_t cmd;
  fcfs_sts_t sts;

  // sequencing
  fcfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic and state
  fcfs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .operation (operation),
    .sample    (sample),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .empty_res (empty_res)
  );

endmodule

[rtl/core/fcfs_check.sv]
// Port-level checker for feedback_comb_filter_stats, bound to the top level.
// Depends on fcfs_pkg.
module fcfs_check (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [fcfs_pkg::SAMPLE_W-1:0] value,
  input logic                                 empty_res
);
  import fcfs_pkg::*;

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(empty_res))
    else $error("result changed or dropped while stalled");

  // one request in flight: no accept right after an accept
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // an empty average reports zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> value == '0)
    else $error("empty average with nonzero value");

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // an accept is never followed directly by a rising result valid
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared too soon after request");

endmodule

bind feedback_comb_filter_stats fcfs_check u_fcfs_check (.*);

[dv/fcfs_checker.sv]
// Checker for the feedback comb filter with running statistics: watches the
// config port, the request channel and the result channel, predicts each result and compares it.
// Depends on fcfs_pkg.
module fcfs_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fcfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fcfs_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [fcfs_pkg::OP_W-1:0]            operation,
  input  logic signed [fcfs_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [fcfs_pkg::SAMPLE_W-1:0] value,
  input  logic                                 empty_res,
  output int                                   errors,
  output int                                   pending
);

  import fcfs_pkg::*;

  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       empty;
  } filter_result_t;

  // Ring of expected results, oldest at exp_head
  filter_result_t awaited_results[EXP_DEPTH];
  int             exp_head;
  int             exp_count;

  // Shadow copy of the block's settings and state
  logic signed [GAIN_W-1:0]   gain_reg;
  logic [DELAY_W-1:0]         delay_reg;
  logic signed [SAMPLE_W-1:0] history[MAX_DELAY];
  logic [PTR_W-1:0]           wr_ptr;
  longint                     acc_sum;
  logic [COUNT_W-1:0]         acc_count;
  logic signed [SAMPLE_W-1:0] peak;

  initial begin
    errors    = 0;
    pending   = 0;
    exp_head  = 0;
    exp_count = 0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Runs one request through the shadow state and returns its result
  function automatic filter_result_t filter_and_track(input logic [OP_W-1:0] op,
                                                      input logic signed [SAMPLE_W-1:0] x);
    filter_result_t res;
    int d;
    logic [PTR_W-1:0] tap;
    longint prod;
    longint y;
    res.value = '0;
    res.empty = 1'b0;
    case (op)
      OP_FILTER: begin
        // delay register is clamped to 1..MAX_DELAY
        d = int'(delay_reg);
        if (d < 1) d = 1;
        if (d > MAX_DELAY) d = MAX_DELAY;
        tap = PTR_W'(int'(wr_ptr) + MAX_DELAY - d);
        // Q1.15 feedback term, rounded half up, then add x and saturate
        prod = longint'(gain_reg) * longint'(history[tap]);
        y = ((prod + 16384) >>> 15) + longint'(x);
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        history[wr_ptr] = SAMPLE_W'(y);
        wr_ptr = wr_ptr + 1'b1;
        res.value = SAMPLE_W'(y);
        // sum and count hold once the count is full
        if (acc_count != '1) begin
          acc_sum   = acc_sum + y;
          acc_count = acc_count + 1'b1;
        end
        if (res.value > peak) peak = res.value;
      end
      OP_AVG: begin
        if (acc_count == '0) begin
          res.empty = 1'b1;
        end else begin
          res.value = SAMPLE_W'(acc_sum / longint'(acc_count));
        end
        acc_sum   = 0;
        acc_count = '0;
      end
      OP_MAX: begin
        res.value = peak;
        peak      = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    filter_result_t want;
    if (rst) begin
      gain_reg  = '0;
      delay_reg = DELAY_W'(2);
      for (int i = 0; i < MAX_DELAY; i++) history[i] = '0;
      wr_ptr    = '0;
      acc_sum   = 0;
      acc_count = '0;
      peak      = '0;
      exp_head  = 0;
      exp_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GAIN) gain_reg = cfg_data;
        else if (cfg_index == CFG_DELAY) delay_reg = cfg_data[DELAY_W-1:0];
      end
      // result side
      if (out_valid && out_ready) begin
        if (exp_count == 0) begin
          report_mismatch($sformatf("result %0d/%0b with no request outstanding",
                                    value, empty_res));
        end else begin
          want      = awaited_results[exp_head];
          exp_head  = (exp_head + 1) % EXP_DEPTH;
          exp_count = exp_count - 1;
          if (value !== want.value)
            report_mismatch($sformatf("value %0d, expected %0d", value, want.value));
          if (empty_res !== want.empty)
            report_mismatch($sformatf("empty_res %0b, expected %0b", empty_res, want.empty));
        end
      end
      // request side
      if (in_valid && in_ready) begin
        if (exp_count == EXP_DEPTH) begin
          report_mismatch("more requests outstanding than the block can hold");
        end else begin
          awaited_results[(exp_head + exp_count) % EXP_DEPTH] =
            filter_and_track(operation, sample);
          exp_count = exp_count + 1;
        end
      end
    end
    pending = exp_count;
  end

endmodule

[dv/tb_feedback_comb_filter_stats.sv]
// Testbench top for the feedback comb filter with running statistics: clock,
// reset, request stimulus, result back-pressure and the verdict.
// Depends on fcfs_pkg, feedback_comb_filter_stats and fcfs_checker.
module tb_feedback_comb_filter_stats;

  import fcfs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int SEG_ITEMS   = 115;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [OP_W-1:0]            operation;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] value;
  logic                       empty_res;

  int errors;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  feedback_comb_filter_stats i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .empty_res (empty_res)
  );

  fcfs_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .empty_res (empty_res),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result back-pressure, with an optional long hold-off
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run after too long without any handshake
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input logic [OP_W-1:0] op, input logic signed [SAMPLE_W-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    sample    <= x;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(19))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Mostly filter requests, with occasional reads and the unused code
  task automatic send_random(input int n);
    int k;
    logic [OP_W-1:0] op;
    repeat (n) begin
      k = $urandom_range(99);
      if (k < 84) op = OP_FILTER;
      else if (k < 91) op = OP_AVG;
      else if (k < 97) op = OP_MAX;
      else op = OP_UNUSED;
      send_req(op, pick_sample());
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Registers change only with the block idle
  task automatic set_filter(input logic signed [GAIN_W-1:0] gain, input logic [DELAY_W-1:0] dly);
    drain();
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GAIN;
    cfg_data  <= gain;
    @(negedge clk);
    cfg_index <= CFG_DELAY;
    cfg_data  <= CFG_W'(dly);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic signed [GAIN_W-1:0] g;
    logic [DELAY_W-1:0] d;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    operation     = OP_FILTER;
    sample        = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero gain passes samples through, delay 2
    send_req(OP_AVG, 16'sh1234);      // empty average
    send_req(OP_MAX, '0);             // max starts at zero
    send_req(OP_UNUSED, 16'sh8000);
    send_req(OP_FILTER, 16'sh7FFF);
    send_req(OP_FILTER, 16'sh8000);
    send_req(OP_FILTER, '0);
    send_req(OP_FILTER, '1);
    send_req(OP_FILTER, 16'sh0ABC);
    send_req(OP_MAX, 16'sh5555);
    send_req(OP_AVG, '0);
    send_req(OP_AVG, '0);             // cleared, so empty again

    // Most negative gain; delay 0 acts as 1
    set_filter(16'sh8000, 5'd0);
    send_req(OP_FILTER, 16'sh8000);
    send_req(OP_FILTER, 16'sh8000);
    send_req(OP_FILTER, 16'sh7FFF);
    send_req(OP_FILTER, 16'sh4000);
    send_req(OP_AVG, '0);
    send_req(OP_MAX, '0);

    // Largest gain; delay above range acts as MAX_DELAY
    set_filter(16'sh7FFF, 5'd17);
    send_req(OP_FILTER, 16'sh7FFF);
    send_req(OP_FILTER, 16'sh7FFF);
    send_req(OP_FILTER, 16'sh7FFF);
    send_req(OP_UNUSED, 16'sh7FFF);

    // Random segments: slow receiver, then slow sender, then no idling
    for (int seg = 0; seg < 12; seg++) begin
      case (seg / 4)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg)
        0:  begin g = 16'sh7FFF;          d = 5'd1;  end
        1:  begin g = 16'sh8000;          d = 5'd16; end
        2:  begin g = '0;                 d = 5'd2;  end
        3:  begin g = 16'sh4000;          d = 5'd0;  end
        4:  begin g = -16'sd16384;        d = 5'd31; end
        6:  begin g = 16'sh7FFF;          d = 5'd16; end
        7:  begin g = 16'sh8000;          d = 5'd1;  end
        8:  begin g = GAIN_W'($urandom()); d = DELAY_W'($urandom_range(31)); end
        9:  begin g = 16'sd23170;         d = 5'd3;  end
        10: begin g = '1;                 d = 5'd8;  end
        default: begin
          g = GAIN_W'($urandom());
          d = DELAY_W'($urandom_range(16, 1));
        end
      endcase
      set_filter(g, d);
      // long receiver hold-off while requests keep coming: the block backs up
      if (seg == 8) begin
        hold_cycles = 150;
        send_random(24);
      end
      send_random(SEG_ITEMS);
    end

    drain();
    repeat (60) @(negedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
